// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, command word and state encodings shared
// by the front end, command queue, back end and top level.
// ----------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned HEADER_ROWS = 2;
  localparam int unsigned CELLS       = ROWS * COLUMNS;
  localparam int unsigned ADDR_W      = $clog2(CELLS);

  // Field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CELL_W = ATTR_W + CHAR_W;

  // Character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FILL_ATTR = '0;
  localparam logic [ATTR_W-1:0]    FILL_ATTR_RESET = 8'd2;

  // Command queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Address landmarks for the block moves
  localparam bit HAS_COPY = (HEADER_ROWS + 1) < ROWS;
  localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_FIRST     = ADDR_W'((HEADER_ROWS + 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_OFS       = ADDR_W'(COLUMNS + 1);
  localparam logic [ADDR_W-1:0] COPY_TAIL_ADDR = ADDR_W'(CELLS - 1 - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] CLEAR_FIRST    = ADDR_W'(HEADER_ROWS * COLUMNS);

  typedef enum logic [1:0] {
    OP_PUT,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } cmd_op_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_PUT,
    BK_COPY,
    BK_COPY_TAIL,
    BK_FILL,
    BK_READ,
    BK_DONE
  } back_state_e;

  // One classified word handed from the front end to the back end
  typedef struct packed {
    cmd_op_e           op;
    logic              wr_en;
    logic              scroll;
    logic              rd_ok;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [31:0] lin;
    lin = 32'(row) * 32'(COLUMNS) + 32'(col);
    return lin[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/text_console_writer_with_scroll.sv
// ----------------------------------------------------------------------
// Text console writer with scroll
// Order: a printable put writes its cell and an in-range read fetches its
//   cell before reporting; a newline that does not scroll, an out-of-range
//   read and an unused code report without touching memory. A scroll copies
//   the text rows up and fills the last row, and a clear fills all rows below
//   the header, through the single write port of the screen memory (one cell a
//   cycle). Two commands can queue ahead of the sequencer while it works.
// Reset: screen memory is swept to zero with busy high.
// ----------------------------------------------------------------------
module text_console_writer_with_scroll
  import tcw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [ATTR_W-1:0]     attribute_i,
  input  logic [ROW_W-1:0]      read_row_i,
  input  logic [COL_W-1:0]      read_col_i,
  // Result channel
  output logic                  done_o,
  output logic [ROW_W-1:0]      cursor_row_o,
  output logic [COL_W-1:0]      cursor_col_o,
  output logic                  scrolled_o,
  output logic [CELL_W-1:0]     cell_data_o,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic              accept;
  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  cmd_t              head;
  logic              init_busy;
  logic              reg_hit;
  logic [ATTR_W-1:0] fill_attr_q;

  // Take a word only when the queue has room and the reset sweep is over
  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  // Configuration register: attribute of the blank row after a scroll
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_FILL_ATTR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_attr_q <= FILL_ATTR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      fill_attr_q <= pwdata[ATTR_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DATA_W'(fill_attr_q) : '0;

  // Front end: cursor tracking and command build
  tcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .char_code_i (char_code_i),
    .attribute_i (attribute_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decouple the front end from the memory sequencer
  tcw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // Back end: screen memory sequencer and result register
  tcw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .fill_attr_i  (fill_attr_q),
    .pop_o        (pop),
    .init_o       (init_busy),
    .done_o       (done_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o),
    .cell_data_o  (cell_data_o)
  );

endmodule

// File: hdl/tcw_ram.sv
// ----------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tcw_front.sv
// ----------------------------------------------------------------------
// Text console front end
// Track the cursor, classify each accepted word and build its command.
// ----------------------------------------------------------------------
module tcw_front
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ATTR_W-1:0] attribute_i,
  input  logic [ROW_W-1:0]  read_row_i,
  input  logic [COL_W-1:0]  read_col_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic [ROW_W-1:0] cur_row_q, cur_row_d;
  logic [COL_W-1:0] cur_col_q, cur_col_d;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W:0]   row_wide;
  logic [COL_W:0]   col_inc;
  cmd_t             cmd;

  assign row_inc = {1'b0, cur_row_q} + 1'b1;
  assign col_inc = {1'b0, cur_col_q} + 1'b1;

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NOP;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    row_wide  = {1'b0, cur_row_q};
    unique case (func_i)
      FUNC_PUT: begin
        cmd.op    = OP_PUT;
        cmd.wr_en = (char_code_i != NEWLINE_CODE);
        cmd.addr  = cell_addr(cur_row_q, cur_col_q);
        cmd.data  = {attribute_i, char_code_i};
        if (char_code_i == NEWLINE_CODE) begin
          row_wide  = row_inc;
          cur_col_d = '0;
        end else if (32'(col_inc) >= COLUMNS) begin
          row_wide  = row_inc;
          cur_col_d = '0;
        end else begin
          cur_col_d = col_inc[COL_W-1:0];
        end
        // Passing the bottom row scrolls and parks the cursor on the last row
        if (32'(row_wide) >= ROWS) begin
          cmd.scroll = 1'b1;
          cur_row_d  = ROW_W'(ROWS - 1);
          cur_col_d  = '0;
        end else begin
          cur_row_d = row_wide[ROW_W-1:0];
        end
      end
      FUNC_CLEAR: begin
        cmd.op    = OP_CLEAR;
        cmd.data  = {attribute_i, SPACE_CODE};
        cur_row_d = ROW_W'(HEADER_ROWS);
        cur_col_d = '0;
      end
      FUNC_READ: begin
        cmd.op    = OP_READ;
        cmd.rd_ok = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLUMNS);
        cmd.addr  = cell_addr(read_row_i, read_col_i);
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
    cmd.cur_row = cur_row_d;
    cmd.cur_col = cur_col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
    end else if (accept_i) begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
    end
  end

  assign push_o = accept_i;
  assign cmd_o  = cmd;

endmodule

// File: hdl/tcw_queue.sv
// ----------------------------------------------------------------------
// Text console command queue
// Short FIFO of commands between the front end and the back end.
// ----------------------------------------------------------------------
module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (32'(count_q) == QUEUE_DEPTH);
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/tcw_back.sv
// ----------------------------------------------------------------------
// Text console back end
// Own the screen memory: clear it after reset, then carry out commands
// (cell write, scroll copy, row fill, cell read) and report each result.
// ----------------------------------------------------------------------
module tcw_back
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cmd_t              head_i,
  input  logic [ATTR_W-1:0] fill_attr_i,
  output logic              pop_o,
  output logic              init_o,
  output logic              done_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic              scrolled_o,
  output logic [CELL_W-1:0] cell_data_o
);

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  cmd_t              cmd_q, cmd_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic              done_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              scrolled_q;
  logic [CELL_W-1:0] cell_q;

  // Next state
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    fill_d  = fill_q;
    cmd_d   = cmd_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BK_INIT: begin
        if (ptr_q == LAST_ADDR) begin
          state_d = BK_IDLE;
          ptr_d   = '0;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          unique case (head_i.op)
            OP_PUT: begin
              if (head_i.wr_en) begin
                state_d = BK_PUT;
              end else if (head_i.scroll) begin
                state_d = HAS_COPY ? BK_COPY : BK_FILL;
                ptr_d   = HAS_COPY ? COPY_FIRST : LAST_ROW_FIRST;
                fill_d  = {fill_attr_i, SPACE_CODE};
              end else begin
                state_d = BK_DONE;
              end
            end
            OP_CLEAR: begin
              state_d = BK_FILL;
              ptr_d   = CLEAR_FIRST;
              fill_d  = head_i.data;
            end
            OP_READ: begin
              state_d = head_i.rd_ok ? BK_READ : BK_DONE;
            end
            default: begin
              state_d = BK_DONE;
            end
          endcase
        end
      end
      BK_PUT: begin
        if (cmd_q.scroll) begin
          state_d = HAS_COPY ? BK_COPY : BK_FILL;
          ptr_d   = HAS_COPY ? COPY_FIRST : LAST_ROW_FIRST;
          fill_d  = {fill_attr_i, SPACE_CODE};
        end else begin
          state_d = BK_DONE;
        end
      end
      BK_COPY: begin
        if (ptr_q == LAST_ADDR) begin
          state_d = BK_COPY_TAIL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      BK_COPY_TAIL: begin
        state_d = BK_FILL;
        ptr_d   = LAST_ROW_FIRST;
      end
      BK_FILL: begin
        if (ptr_q == LAST_ADDR) begin
          state_d = BK_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      BK_READ: begin
        state_d = BK_DONE;
      end
      BK_DONE: begin
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Memory controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = fill_q;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    unique case (state_q)
      BK_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      BK_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cmd_q.addr;
        ram_wdata = cmd_q.data;
      end
      BK_COPY: begin
        // Read one cell ahead, write the previous one a row up
        ram_re    = 1'b1;
        ram_we    = (ptr_q != COPY_FIRST);
        ram_waddr = ptr_q - COPY_OFS;
        ram_wdata = ram_rdata;
      end
      BK_COPY_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = COPY_TAIL_ADDR;
        ram_wdata = ram_rdata;
      end
      BK_FILL: begin
        ram_we = 1'b1;
      end
      BK_READ: begin
        ram_re    = 1'b1;
        ram_raddr = cmd_q.addr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_INIT;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      done_q  <= (state_q == BK_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    cmd_q  <= cmd_d;
    if (state_q == BK_DONE) begin
      row_q      <= cmd_q.cur_row;
      col_q      <= cmd_q.cur_col;
      scrolled_q <= cmd_q.scroll;
      cell_q     <= (cmd_q.op == OP_READ && cmd_q.rd_ok) ? ram_rdata : '0;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign init_o       = (state_q == BK_INIT);
  assign done_o       = done_q;
  assign cursor_row_o = row_q;
  assign cursor_col_o = col_q;
  assign scrolled_o   = scrolled_q;
  assign cell_data_o  = cell_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// Text console writer with scroll: self-checking testbench
// Feeds command words through the start/busy channel and checks every
// reported cursor, scroll flag and read cell against a cycle-free model of
// the 80x25 screen. The scroll fill attribute is set over the APB port
// between phases, and each phase uses a different amount of sender idling.
// ----------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 5;
  // Settling time after the last report, with a comfortable margin.
  localparam int unsigned DRAIN_CYCLES = 16;
  // Scrolls and clears walk screen memory cell by cell; allow several times a run
  // in which every word scrolls.
  localparam longint unsigned TIMEOUT_NS = 200_000_000;

  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE   = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } console_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
  } console_report_t;

  // DUT connections; the inputs are all known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     func_i      = '0;
  logic [CHAR_W-1:0]     char_code_i = '0;
  logic [ATTR_W-1:0]     attribute_i = '0;
  logic [ROW_W-1:0]      read_row_i  = '0;
  logic [COL_W-1:0]      read_col_i  = '0;
  logic                  done_o;
  logic [ROW_W-1:0]      cursor_row_o;
  logic [COL_W-1:0]      cursor_col_o;
  logic                  scrolled_o;
  logic [CELL_W-1:0]     cell_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Words waiting to be sent, and reports predicted for accepted words
  console_word_t   pending_words[$];
  console_report_t predicted_reports[$];
  int unsigned     words_queued = 0;
  int unsigned     idle_pct     = 0;
  int unsigned     mismatches   = 0;

  // Shadow of the screen, cursor and fill register
  logic [CELL_W-1:0] screen_shadow [CELLS];
  int unsigned       shadow_row  = 0;
  int unsigned       shadow_col  = 0;
  logic [ATTR_W-1:0] shadow_fill = FILL_ATTR_RESET;

  initial begin
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = '0;
  end

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  text_console_writer_with_scroll u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .attribute_i  (attribute_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .done_o       (done_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o),
    .cell_data_o  (cell_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Advance the shadow screen by one accepted word and queue its report.
  task automatic advance_console(input console_word_t w);
    console_report_t rep;
    rep = '0;
    case (w.func)
      FUNC_PUT: begin
        if (w.char_code == NEWLINE_CODE) begin
          // Newline: next row, column 0, no cell written
          shadow_row++;
          shadow_col = 0;
        end else begin
          if (shadow_row < ROWS && shadow_col < COLUMNS)
            screen_shadow[shadow_row * COLUMNS + shadow_col] = {w.attribute, w.char_code};
          shadow_col++;
          if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        if (shadow_row >= ROWS) begin
          // Scroll the text area up one row; header rows stay put
          for (int y = HEADER_ROWS + 1; y < ROWS; y++)
            for (int x = 0; x < COLUMNS; x++)
              screen_shadow[(y - 1) * COLUMNS + x] = screen_shadow[y * COLUMNS + x];
          for (int x = 0; x < COLUMNS; x++)
            screen_shadow[(ROWS - 1) * COLUMNS + x] = {shadow_fill, SPACE_CODE};
          shadow_row   = ROWS - 1;
          shadow_col   = 0;
          rep.scrolled = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        for (int y = HEADER_ROWS; y < ROWS; y++)
          for (int x = 0; x < COLUMNS; x++)
            screen_shadow[y * COLUMNS + x] = {w.attribute, SPACE_CODE};
        shadow_row = HEADER_ROWS;
        shadow_col = 0;
      end
      FUNC_READ: begin
        if (w.read_row < ROWS && w.read_col < COLUMNS)
          rep.cell_data = screen_shadow[w.read_row * COLUMNS + w.read_col];
      end
      default: ;
    endcase
    rep.cursor_row = ROW_W'(shadow_row);
    rep.cursor_col = COL_W'(shadow_col);
    predicted_reports.push_back(rep);
  endtask

  // --------------------------------------------------------------------
  // Driver: present the head of the pending queue, hold it until busy is
  // low at an edge, then advance the shadow. Drop start for idle cycles.
  // --------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_words
    console_word_t nxt;
    bit            taken;
    taken = rst_ni && start && !busy;
    if (taken) advance_console(pending_words.pop_front());
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold the word until the block takes it
    end else if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
      nxt         = pending_words[0];
      start       <= 1'b1;
      func_i      <= nxt.func;
      char_code_i <= nxt.char_code;
      attribute_i <= nxt.attribute;
      read_row_i  <= nxt.read_row;
      read_col_i  <= nxt.read_col;
    end else begin
      start <= 1'b0;
    end
  end

  // --------------------------------------------------------------------
  // Monitor: every done strobe carries one report; match it against the
  // oldest prediction.
  // --------------------------------------------------------------------
  always @(posedge clk_i) begin : check_reports
    console_report_t got, want;
    if (rst_ni && done_o) begin
      got = {cursor_row_o, cursor_col_o, scrolled_o, cell_data_o};
      if (predicted_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected word row=%0d col=%0d scrolled=%0b cell=%h",
                                got.cursor_row, got.cursor_col, got.scrolled,
                                got.cell_data));
      end else begin
        want = predicted_reports.pop_front();
        if (got !== want)
          note_mismatch($sformatf(
            "row %0d/%0d col %0d/%0d scrolled %0b/%0b cell %h/%h (got/expected)",
            got.cursor_row, want.cursor_row, got.cursor_col, want.cursor_col,
            got.scrolled, want.scrolled, got.cell_data, want.cell_data));
      end
    end
  end

  task automatic queue_word(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                            input logic [ATTR_W-1:0] attr, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col);
    pending_words.push_back('{func, ch, attr, row, col});
    words_queued++;
  endtask

  // Random traffic built mostly from text lines, with reads, newline runs,
  // clears and unused codes mixed in.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned stop_at, kind, len, sel;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    stop_at = words_queued + count;
    while (words_queued < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        // One line of text; some lines run past the last column and wrap
        len = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(20);
        repeat (len) begin
          ch = CHAR_W'($urandom_range(255));
          if (ch == NEWLINE_CODE) ch = SPACE_CODE;
          queue_word(FUNC_PUT, ch, ATTR_W'($urandom_range(255)),
                     ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
        end
        if ($urandom_range(9) < 7)
          queue_word(FUNC_PUT, NEWLINE_CODE, ATTR_W'($urandom_range(255)),
                     ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
      end else if (kind < 85) begin
        // Reads, many of them where fresh text lands
        repeat ($urandom_range(3, 1)) begin
          sel = $urandom_range(99);
          if (sel < 40) begin
            row = ROW_W'(ROWS - 1 - $urandom_range(1));
            col = COL_W'($urandom_range(COLUMNS - 1));
          end else if (sel < 65) begin
            row = ROW_W'($urandom_range(ROWS - 1));
            col = COL_W'($urandom_range(COLUMNS - 1));
          end else if (sel < 80) begin
            row = ROW_W'($urandom_range(HEADER_ROWS - 1));
            col = COL_W'($urandom_range(COLUMNS - 1));
          end else begin
            row = ROW_W'($urandom_range(31));
            col = COL_W'($urandom_range(127));
          end
          queue_word(FUNC_READ, CHAR_W'($urandom_range(255)),
                     ATTR_W'($urandom_range(255)), row, col);
        end
      end else if (kind < 92) begin
        queue_word(FUNC_PUT, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                   ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
      end else if (kind < 95) begin
        // Newline run: at the bottom row every newline scrolls
        repeat ($urandom_range(25, 2))
          queue_word(FUNC_PUT, NEWLINE_CODE, ATTR_W'($urandom_range(255)),
                     ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
      end else if (kind < 97) begin
        queue_word(FUNC_UNUSED, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                   ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
      end else begin
        queue_word(FUNC_CLEAR, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
                   ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
      end
    end
  endtask

  // Hold off until every word is sent and reported, then let the block settle.
  task automatic drain_words();
    while (pending_words.size() != 0 || start || predicted_reports.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, access phase, then idle with psel low.
  task automatic apb_transfer(input logic write, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_fill_attr();
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b0, REG_FILL_ATTR, '0, rd);
    if (rd !== APB_DATA_W'(shadow_fill))
      note_mismatch($sformatf("fill attribute read %h expected %h", rd, shadow_fill));
  endtask

  task automatic set_fill_attr(input logic [REG_IDX_W-1:0] idx,
                               input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] unused_rd;
    apb_transfer(1'b1, idx, value, unused_rd);
    if (idx == REG_FILL_ATTR) shadow_fill = value[ATTR_W-1:0];
    check_fill_attr();
  endtask

  // --------------------------------------------------------------------
  // Stimulus: reset, a directed opening, then random phases that differ
  // in fill attribute and sender idling.
  // --------------------------------------------------------------------
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Wait out the memory sweep before touching the register
    while (busy) @(posedge clk_i);
    check_fill_attr();

    // Directed opening: cursor still in the header rows after reset
    idle_pct = 0;
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_word(FUNC_PUT, 8'h41, 8'h00, 5'd31, 7'd127);
    queue_word(FUNC_PUT, 8'hFF, 8'hFF, 5'd0, 7'd0);
    queue_word(FUNC_PUT, 8'h80, 8'h80, 5'd0, 7'd0);
    queue_word(FUNC_PUT, 8'h00, 8'h7F, 5'd0, 7'd0);
    queue_word(FUNC_PUT, NEWLINE_CODE, 8'hFF, 5'd0, 7'd0);
    // High character bytes must come back without sign extension
    queue_word(FUNC_READ, 8'hFF, 8'hFF, 5'd0, 7'd1);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd2);
    // Reads outside the screen return zero; the last cell is read as well
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd25, 7'd0);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd31, 7'd127);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd80);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd24, 7'd79);
    // Unused code leaves everything alone
    queue_word(FUNC_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127);
    // Clear keeps the header rows and homes the cursor below them
    queue_word(FUNC_CLEAR, 8'h00, 8'h55, 5'd0, 7'd0);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd24, 7'd79);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd2, 7'd0);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_word(FUNC_CLEAR, 8'h00, 8'hFF, 5'd0, 7'd0);
    queue_word(FUNC_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
    queue_word(FUNC_PUT, 8'hFE, 8'h01, 5'd0, 7'd0);
    queue_word(FUNC_READ, 8'h00, 8'h00, 5'd2, 7'd0);
    drain_words();

    // Back to back, fill attribute at its upper extreme
    set_fill_attr(REG_FILL_ATTR, 32'h0000_00FF);
    queue_random_traffic(480);
    drain_words();

    // Heavy sender idling, fill attribute zero
    set_fill_attr(REG_FILL_ATTR, 32'h0000_0000);
    idle_pct = 78;
    queue_random_traffic(480);
    drain_words();

    // Out-of-range register index must leave the fill attribute alone
    set_fill_attr(REG_SPARE, $urandom);
    idle_pct = 9;
    queue_random_traffic(480);
    drain_words();

    // Random fill value; upper data bits are ignored
    set_fill_attr(REG_FILL_ATTR, $urandom);
    idle_pct = 30;
    queue_random_traffic(480);
    drain_words();

    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
